FILE: sv/keyed_ring_fifo_unit_macros.svh
// Assertion macros shared by the keyed ring FIFO modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef KEYED_RING_FIFO_UNIT_MACROS_SVH
`define KEYED_RING_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/krf_pkg.sv
// Package for the keyed ring FIFO: command codes, field widths and types.
// No dependencies; used by all keyed ring FIFO modules.
`timescale 1ns / 1ps

package krf_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int KEY_W   = 32;
  localparam int PAY_W   = 32;
  localparam int FILL_W  = 8;
  localparam int COUNT_W = 32;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_MATCH = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } command_t;

  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic [FILL_W-1:0]  fill_count;
    logic [COUNT_W-1:0] overflow_count;
    logic [COUNT_W-1:0] underflow_count;
  } result_t;

endpackage

FILE: sv/keyed_ring_fifo_unit.sv
// Keyed ring FIFO: push, pop and pop-on-key-match over a ring of key/payload entries.
// A command waits in the input register until it is processed; its result beat waits
// in the result register until taken. One command per cycle unless the result channel stalls.
// The head entry sits in the store's registered read port, so back-to-back pops need no wait.
// Reset (rst, synchronous, active high) clears the slot pointers, both refusal counters
// and the valid flags; the entry store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module keyed_ring_fifo_unit #(
  parameter int DEPTH = krf_pkg::DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // Command channel.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // item_key [31:0], item_payload [63:32]
  input  logic [1:0]   s_tuser,   // command [1:0]
  // Result channel.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // out_key [31:0], out_payload [63:32], fill_count [71:64],
                                  // overflow_count [103:72], underflow_count [135:104]
  output logic [0:0]   m_tuser    // ok [0]
);

  localparam int PW = $clog2(DEPTH);

  // Input register: one command beat waiting to be processed.
  logic              in_valid;
  krf_pkg::command_t in_cmd;

  // Result register: one result beat waiting to be taken.
  logic             out_valid;
  krf_pkg::result_t out_res;

  logic             proc;
  krf_pkg::result_t res;
  krf_pkg::entry_t  head;
  krf_pkg::entry_t  wdata;
  logic             we;
  logic [PW-1:0]    waddr;
  logic [PW-1:0]    raddr;

  // A held command is processed when the result register is free or being emptied;
  // a new beat enters whenever the input register is free or being processed.
  assign proc     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd.command <= s_tuser;
      in_cmd.key     <= s_tdata[31:0];
      in_cmd.payload <= s_tdata[63:32];
    end
  end

  krf_ctrl #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .proc  (proc),
    .cmd   (in_cmd),
    .head  (head),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .res   (res)
  );

  krf_store #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_res <= res;
    end
  end

  assign m_tvalid         = out_valid;
  assign m_tuser[0]       = out_res.ok;
  assign m_tdata[31:0]    = out_res.key;
  assign m_tdata[63:32]   = out_res.payload;
  assign m_tdata[71:64]   = out_res.fill_count;
  assign m_tdata[103:72]  = out_res.overflow_count;
  assign m_tdata[135:104] = out_res.underflow_count;

endmodule

FILE: sv/krf_store.sv
// Entry store of the keyed ring FIFO: one write port, one registered read port.
// Depends on krf_pkg for the entry type.
`timescale 1ns / 1ps

module krf_store #(
  parameter int DEPTH = krf_pkg::DEPTH_DEFAULT,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [PW-1:0]   waddr,
  input  krf_pkg::entry_t wdata,
  input  logic [PW-1:0]   raddr,
  output krf_pkg::entry_t rdata
);

  krf_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A write to the slot being read shows up in the read register at once.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/krf_ctrl.sv
// Command logic of the keyed ring FIFO: slot pointers, refusal counters, result.
// Depends on krf_pkg and keyed_ring_fifo_unit_macros.svh.
`timescale 1ns / 1ps
`include "keyed_ring_fifo_unit_macros.svh"

module krf_ctrl #(
  parameter int DEPTH = krf_pkg::DEPTH_DEFAULT,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              proc,
  input  krf_pkg::command_t cmd,
  input  krf_pkg::entry_t   head,
  output logic              we,
  output logic [PW-1:0]     waddr,
  output krf_pkg::entry_t   wdata,
  output logic [PW-1:0]     raddr,
  output krf_pkg::result_t  res
);

  logic [PW-1:0] write_slot, write_slot_next;
  logic [PW-1:0] read_slot, read_slot_next;
  logic [krf_pkg::COUNT_W-1:0] refused_pushes, refused_pushes_next;
  logic [krf_pkg::COUNT_W-1:0] refused_pops, refused_pops_next;

  logic          full;
  logic          empty;
  logic [PW-1:0] fill_now;
  logic [PW-1:0] fill_after;
  logic [31:0]   fill_wide;

  assign full     = (write_slot == read_slot);
  assign fill_now = read_slot - write_slot - 1'b1;
  assign empty    = (fill_now == '0);

  always_comb begin
    write_slot_next     = write_slot;
    read_slot_next      = read_slot;
    refused_pushes_next = refused_pushes;
    refused_pops_next   = refused_pops;
    we                  = 1'b0;
    res.ok              = 1'b0;
    res.key             = '0;
    res.payload         = '0;
    if (proc) begin
      case (cmd.command)
        krf_pkg::CMD_PUSH: begin
          if (!full) begin
            we              = 1'b1;
            write_slot_next = write_slot - 1'b1;
            res.ok          = 1'b1;
          end else begin
            refused_pushes_next = refused_pushes + 1'b1;
          end
        end
        krf_pkg::CMD_POP: begin
          if (!empty) begin
            read_slot_next = read_slot - 1'b1;
            res.ok         = 1'b1;
            res.key        = head.key;
            res.payload    = head.payload;
          end else begin
            refused_pops_next = refused_pops + 1'b1;
          end
        end
        krf_pkg::CMD_POP_MATCH: begin
          if (!empty && (head.key == cmd.key)) begin
            read_slot_next = read_slot - 1'b1;
            res.ok         = 1'b1;
            res.key        = head.key;
            res.payload    = head.payload;
          end
        end
        default: begin
        end
      endcase
    end
    fill_after          = read_slot_next - write_slot_next - 1'b1;
    fill_wide           = 32'(fill_after);
    res.fill_count      = (fill_wide > 32'd255) ? 8'hFF : fill_wide[7:0];
    res.overflow_count  = refused_pushes_next;
    res.underflow_count = refused_pops_next;
  end

  assign waddr         = write_slot;
  assign wdata.key     = cmd.key;
  assign wdata.payload = cmd.payload;
  // Keep the read register loaded with the head entry of the state being entered.
  assign raddr         = read_slot_next - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot     <= PW'(DEPTH - 1);
      read_slot      <= '0;
      refused_pushes <= '0;
      refused_pops   <= '0;
    end else begin
      write_slot     <= write_slot_next;
      read_slot      <= read_slot_next;
      refused_pushes <= refused_pushes_next;
      refused_pops   <= refused_pops_next;
    end
  end

  `KRF_ASSERT_NOW(a_no_write_when_full, clk, rst, we, !full, "write into a full ring")
  `KRF_ASSERT_NEXT(a_idle_holds_slots, clk, rst, !proc,
    $stable(write_slot) && $stable(read_slot), "slot pointer moved without a command")
  `KRF_ASSERT_NEXT(a_pop_moves_head, clk, rst,
    proc && (cmd.command == krf_pkg::CMD_POP) && !empty,
    read_slot == PW'($past(read_slot) - 1'b1), "pop did not advance the read slot")
  `KRF_ASSERT_NEXT(a_full_push_counted, clk, rst,
    proc && (cmd.command == krf_pkg::CMD_PUSH) && full,
    refused_pushes == $past(refused_pushes) + 1'b1, "refused push not counted")

endmodule

FILE: tb/keyed_ring_fifo_unit_checker.sv
// Checker for the keyed ring FIFO: watches both stream channels, predicts every result
// beat and compares it field by field. Depends on krf_pkg for command codes and types.
`timescale 1ns / 1ps

module keyed_ring_fifo_unit_checker #(
  parameter int DEPTH = krf_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [63:0]                  s_tdata,   // item_key [31:0], item_payload [63:32]
  input  logic [1:0]                   s_tuser,   // command [1:0]
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [135:0]                 m_tdata,   // key, payload, fill, overflow, underflow
  input  logic [0:0]                   m_tuser,   // ok [0]
  output int unsigned                  err_count,
  output int unsigned                  pending,
  output int unsigned                  results_checked,
  output int unsigned                  peak_fill,
  output logic [krf_pkg::COUNT_W-1:0]  overflow_total,
  output logic [krf_pkg::COUNT_W-1:0]  underflow_total
);

  // Shadow copy of the ring, its two downward-moving slots and the refusal counters.
  krf_pkg::entry_t              ring [DEPTH];
  int unsigned                  wr_slot;
  int unsigned                  rd_slot;
  logic [krf_pkg::COUNT_W-1:0]  push_refusals;
  logic [krf_pkg::COUNT_W-1:0]  pop_refusals;
  krf_pkg::result_t             expected_q [$];
  int unsigned                  errs;
  int unsigned                  checked;
  int unsigned                  fill_high;

  function automatic int unsigned held_entries();
    return (rd_slot + 2 * DEPTH - wr_slot - 1) % DEPTH;
  endfunction

  function automatic krf_pkg::result_t apply_command(input logic [krf_pkg::CMD_W-1:0] op,
                                                     input logic [krf_pkg::KEY_W-1:0] k,
                                                     input logic [krf_pkg::PAY_W-1:0] p);
    krf_pkg::result_t r;
    int unsigned      head;
    int unsigned      held;
    r    = '0;
    head = (rd_slot + DEPTH - 1) % DEPTH;
    held = held_entries();
    case (op)
      krf_pkg::CMD_PUSH: begin
        if (wr_slot != rd_slot) begin
          ring[wr_slot].key     = k;
          ring[wr_slot].payload = p;
          wr_slot = (wr_slot + DEPTH - 1) % DEPTH;
          r.ok    = 1'b1;
        end else begin
          push_refusals++;
        end
      end
      krf_pkg::CMD_POP: begin
        if (held > 0) begin
          rd_slot   = head;
          r.key     = ring[head].key;
          r.payload = ring[head].payload;
          r.ok      = 1'b1;
        end else begin
          pop_refusals++;
        end
      end
      krf_pkg::CMD_POP_MATCH: begin
        // A mismatch or an empty ring leaves everything untouched, counters included.
        if (held > 0 && ring[head].key == k) begin
          rd_slot   = head;
          r.key     = ring[head].key;
          r.payload = ring[head].payload;
          r.ok      = 1'b1;
        end
      end
      default: begin
      end
    endcase
    held = held_entries();
    if (held > fill_high) fill_high = held;
    r.fill_count      = (held > 255) ? 8'd255 : held[7:0];
    r.overflow_count  = push_refusals;
    r.underflow_count = pop_refusals;
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : watch
    krf_pkg::result_t want;
    krf_pkg::result_t got;
    if (rst) begin
      wr_slot       = DEPTH - 1;
      rd_slot       = 0;
      push_refusals = '0;
      pop_refusals  = '0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_q.push_back(apply_command(s_tuser, s_tdata[31:0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        got.ok              = m_tuser[0];
        got.key             = m_tdata[31:0];
        got.payload         = m_tdata[63:32];
        got.fill_count      = m_tdata[71:64];
        got.overflow_count  = m_tdata[103:72];
        got.underflow_count = m_tdata[135:104];
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %0h", $time, got);
          errs++;
        end else begin
          want = expected_q.pop_front();
          compare_field("ok", want.ok, got.ok);
          compare_field("out_key", want.key, got.key);
          compare_field("out_payload", want.payload, got.payload);
          compare_field("fill_count", want.fill_count, got.fill_count);
          compare_field("overflow_count", want.overflow_count, got.overflow_count);
          compare_field("underflow_count", want.underflow_count, got.underflow_count);
          checked++;
        end
      end
    end
    err_count       <= errs;
    pending         <= expected_q.size();
    results_checked <= checked;
    peak_fill       <= fill_high;
    overflow_total  <= push_refusals;
    underflow_total <= pop_refusals;
  end

endmodule

FILE: tb/keyed_ring_fifo_unit_tb.sv
// Testbench top for the keyed ring FIFO: drives commands, paces the result channel
// and gives the verdict. Depends on krf_pkg, keyed_ring_fifo_unit and the checker.
`timescale 1ns / 1ps

module keyed_ring_fifo_unit_tb;

  // The command field is two bits wide, so the fourth code reaches the block too.
  localparam logic [krf_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned PHASE_ITEMS  = 150;   // commands per idling phase
  localparam int unsigned LEAN_ITEMS   = 200;   // commands per push/pop lean block
  localparam int unsigned HOLD_START   = 60;    // command count that starts the long hold
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_phase_e;

  typedef enum int unsigned {
    LEAN_PUSH,
    LEAN_MIX,
    LEAN_POP
  } lean_e;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;   // item_key [31:0], item_payload [63:32]
  logic [1:0]   s_tuser;   // command [1:0]
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;   // out_key [31:0], out_payload [63:32], fill_count [71:64],
                           // overflow_count [103:72], underflow_count [135:104]
  logic [0:0]   m_tuser;   // ok [0]

  int unsigned                 err_count;
  int unsigned                 pending;
  int unsigned                 results_checked;
  int unsigned                 peak_fill;
  logic [krf_pkg::COUNT_W-1:0] overflow_total;
  logic [krf_pkg::COUNT_W-1:0] underflow_total;

  int unsigned items_sent = 0;
  int unsigned cmd_tally [4];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keyed_ring_fifo_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  keyed_ring_fifo_unit_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .err_count       (err_count),
    .pending         (pending),
    .results_checked (results_checked),
    .peak_fill       (peak_fill),
    .overflow_total  (overflow_total),
    .underflow_total (underflow_total)
  );

  // Offers one command beat and returns once it has been taken. The idling phase follows
  // the number of commands sent so far, so gaps land on every stage of the ring's life.
  task automatic send_cmd(input logic [krf_pkg::CMD_W-1:0] op,
                          input logic [krf_pkg::KEY_W-1:0] k,
                          input logic [krf_pkg::PAY_W-1:0] p);
    idle_phase_e phase;
    phase = idle_phase_e'((items_sent / PHASE_ITEMS) % 4);
    case (phase)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 58;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct  = 9;
        recv_stall_pct = 9;
      end
    endcase
    // Valid is only dropped in a cycle that is then waited out, never lowered and
    // raised again in the same step.
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {p, k};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    cmd_tally[op]++;
  endtask

  // Keys come mostly from a tiny set so that conditional pops hit the head key often;
  // the rest are full-range words so every key bit toggles.
  function automatic logic [krf_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 60) return krf_pkg::KEY_W'($urandom_range(3));
    return $urandom;
  endfunction

  // The lean of a block decides whether the ring climbs toward full or drains to empty.
  // Two push-leaning blocks in a row are enough to run it full and refuse pushes.
  function automatic logic [krf_pkg::CMD_W-1:0] pick_command(input lean_e lean);
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned match_pct;
    roll = $urandom_range(99);
    case (lean)
      LEAN_PUSH: begin
        push_pct  = 85;
        pop_pct   = 7;
        match_pct = 6;
      end
      LEAN_POP: begin
        push_pct  = 10;
        pop_pct   = 55;
        match_pct = 33;
      end
      default: begin
        push_pct  = 45;
        pop_pct   = 28;
        match_pct = 25;
      end
    endcase
    if (roll < push_pct) return krf_pkg::CMD_PUSH;
    if (roll < push_pct + pop_pct) return krf_pkg::CMD_POP;
    if (roll < push_pct + pop_pct + match_pct) return krf_pkg::CMD_POP_MATCH;
    return CMD_UNKNOWN;
  endfunction

  // Result channel pacing. Once, early in the no-idling phase, ready stays low for a long
  // stretch while commands keep coming, so the block backs up and stalls its input.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && items_sent >= HOLD_START) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles, %0d results still expected",
                 $time, cycle_count, pending);
        $display("keyed_ring_fifo_unit_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    lean_e lean;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= krf_pkg::CMD_PUSH;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: refusals on an empty ring, extreme keys and payloads, a
    // conditional pop that misses and one that hits, and the unknown code both on an
    // empty and a loaded ring.
    send_cmd(krf_pkg::CMD_POP, 32'h0000_0000, 32'h0000_0000);
    send_cmd(krf_pkg::CMD_POP_MATCH, 32'h0000_0000, 32'h0000_0000);
    send_cmd(CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(krf_pkg::CMD_PUSH, 32'h0000_0000, 32'h0000_0000);
    send_cmd(krf_pkg::CMD_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(krf_pkg::CMD_PUSH, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_cmd(krf_pkg::CMD_PUSH, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_cmd(krf_pkg::CMD_POP_MATCH, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(krf_pkg::CMD_POP_MATCH, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(CMD_UNKNOWN, 32'h0000_0000, 32'h0000_0000);
    send_cmd(krf_pkg::CMD_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(krf_pkg::CMD_POP_MATCH, 32'hA5A5_A5A4, 32'h0000_0000);
    send_cmd(krf_pkg::CMD_POP_MATCH, 32'hA5A5_A5A5, 32'h0000_0000);
    send_cmd(krf_pkg::CMD_POP, 32'h0000_0000, 32'h0000_0000);
    send_cmd(krf_pkg::CMD_POP, 32'h0000_0000, 32'h0000_0000);
    send_cmd(krf_pkg::CMD_POP_MATCH, 32'h5A5A_5A5A, 32'h0000_0000);

    // Random part in lean blocks: climb, climb, mixed, drain, drain, mixed, repeated.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / LEAN_ITEMS) % 6)
        0, 1:    lean = LEAN_PUSH;
        3, 4:    lean = LEAN_POP;
        default: lean = LEAN_MIX;
      endcase
      send_cmd(pick_command(lean), pick_key(), $urandom);
    end
    s_tvalid <= 1'b0;

    // The pending count is registered in the checker, so step past the next edge before trusting it.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: %0d push, %0d pop, %0d conditional pop, %0d unknown.",
             items_sent, cmd_tally[krf_pkg::CMD_PUSH], cmd_tally[krf_pkg::CMD_POP],
             cmd_tally[krf_pkg::CMD_POP_MATCH], cmd_tally[CMD_UNKNOWN]);
    $display("Checked %0d result beats; fill peaked at %0d, %0d pushes and %0d pops refused.",
             results_checked, peak_fill, overflow_total, underflow_total);
    if (err_count == 0 && pending == 0) begin
      $display("keyed_ring_fifo_unit_tb: done, clean");
    end else begin
      $display("keyed_ring_fifo_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
